>>> rtl/core/asam_pkg.sv
// ----------------------------------------------------------------------------
// asam_pkg
// Shared widths, types and codes of the ADC sample averager.
// ----------------------------------------------------------------------------
`default_nettype none

package asam_pkg;

  localparam int CODE_BITS  = 12;
  localparam int COUNT_BITS = 16;
  localparam int SUM_BITS   = CODE_BITS + COUNT_BITS;
  localparam int WORD_BITS  = 21;
  localparam int CHAN_LSB   = 16;
  localparam int CHAN_BITS  = 5;
  localparam int MV_BITS    = 16;
  localparam int PROD_BITS  = MV_BITS + CODE_BITS;
  localparam int CFG_BITS   = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int LEVEL_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_BITS-1:0] AVG_COUNT_RESET = CFG_BITS'(100);
  localparam logic [CFG_BITS-1:0] REF_MV_RESET    = CFG_BITS'(3302);

  // Register index, taken from paddr bit 2
  localparam logic CFG_IDX_AVG_COUNT = 1'b0;
  localparam logic CFG_IDX_REF_MV    = 1'b1;

  // One finished run, handed from front to back
  typedef struct packed {
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic [CHAN_BITS-1:0]  chan;
  } asam_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } asam_fifo_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } asam_back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/asam_front.sv
// ----------------------------------------------------------------------------
// asam_front
// Unpacks result words, accumulates codes and closes a run at the target.
// ----------------------------------------------------------------------------
`default_nettype none

module asam_front
  import asam_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [WORD_BITS-1:0]    in_result_word,
  input  wire logic [COUNT_BITS-1:0]   target,
  input  wire asam_fifo_status_t       fifo_st,
  output logic                         push,
  output asam_job_t                    push_job
);

  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0]   sum_inc;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CHAN_BITS-1:0]  chan;
  logic                  accept;
  logic                  run_end;

  // Hold input while the queue has no room for a finished run
  assign in_stall = fifo_st.full;
  assign accept   = in_valid && !in_stall;

  assign chan    = in_result_word[CHAN_LSB +: CHAN_BITS];
  assign sum_inc = sum_r + SUM_BITS'(in_result_word[CODE_BITS-1:0]);
  assign cnt_inc = cnt_r + COUNT_BITS'(1);
  assign run_end = (cnt_inc == '0) || (cnt_inc >= target);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    push    = 1'b0;
    if (accept) begin
      if (run_end) begin
        push    = 1'b1;
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_inc;
        cnt_nxt = cnt_inc;
      end
    end
  end

  assign push_job.sum   = sum_inc;
  assign push_job.count = cnt_inc;
  assign push_job.chan  = chan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/asam_fifo.sv
// ----------------------------------------------------------------------------
// asam_fifo
// Two-entry queue of finished runs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module asam_fifo
  import asam_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire asam_job_t     push_job,
  input  wire logic          pop,
  output asam_job_t          pop_job,
  output asam_fifo_status_t  status
);

  asam_job_t             entry_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [LEVEL_BITS-1:0] level_r;

  assign status.full  = (level_r == LEVEL_BITS'(FIFO_DEPTH));
  assign status.empty = (level_r == '0);
  assign pop_job      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + LEVEL_BITS'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LEVEL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_BITS'(FIFO_DEPTH))
    else $error("queue level above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> rtl/core/asam_back.sv
// ----------------------------------------------------------------------------
// asam_back
// Serial divide of a run's sum, millivolt scaling and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module asam_back
  import asam_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire asam_fifo_status_t      fifo_st,
  input  wire asam_job_t              pop_job,
  output logic                        pop,
  input  wire logic [CFG_BITS-1:0]    ref_mv,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CODE_BITS-1:0]        out_mean_code,
  output logic [MV_BITS-1:0]          out_millivolts,
  output logic [CHAN_BITS-1:0]        out_channel
);

  localparam int STEP_BITS = $clog2(CODE_BITS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(CODE_BITS - 1);

  asam_back_state_t state_r, state_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [CODE_BITS-1:0]  quo_r, quo_nxt;
  logic [COUNT_BITS-1:0] div_r, div_nxt;
  logic [CHAN_BITS-1:0]  chan_r, chan_nxt;
  logic [CODE_BITS-1:0]  mean_r, mean_nxt;
  logic [PROD_BITS-1:0]  prod_r, prod_nxt;
  logic [CODE_BITS-1:0]  omean_r, omean_nxt;
  logic [MV_BITS-1:0]    omv_r, omv_nxt;
  logic [CHAN_BITS-1:0]  ochan_r, ochan_nxt;

  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   diff;
  logic                  qbit;

  assign shifted = {rem_r, quo_r[CODE_BITS-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign qbit    = (shifted >= {1'b0, div_r});

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_nxt       = div_r;
    chan_nxt      = chan_r;
    mean_nxt      = mean_r;
    prod_nxt      = prod_r;
    omean_nxt     = omean_r;
    omv_nxt       = omv_r;
    ochan_nxt     = ochan_r;
    pop           = 1'b0;

    // Drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      BK_IDLE: begin
        if (!fifo_st.empty) begin
          pop       = 1'b1;
          rem_nxt   = pop_job.sum[SUM_BITS-1:CODE_BITS];
          quo_nxt   = pop_job.sum[CODE_BITS-1:0];
          div_nxt   = pop_job.count;
          chan_nxt  = pop_job.chan;
          step_nxt  = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        // The mean never exceeds the code range, so only the low bits divide
        if (qbit) begin
          rem_nxt = diff[COUNT_BITS-1:0];
        end else begin
          rem_nxt = shifted[COUNT_BITS-1:0];
        end
        quo_nxt  = {quo_r[CODE_BITS-2:0], qbit};
        step_nxt = step_r + STEP_BITS'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        mean_nxt  = (div_r == '0) ? '0 : quo_r;
        prod_nxt  = PROD_BITS'(ref_mv) * PROD_BITS'((div_r == '0) ? '0 : quo_r);
        state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          omean_nxt     = mean_r;
          omv_nxt       = prod_r[PROD_BITS-1:CODE_BITS];
          ochan_nxt     = chan_r;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    div_r   <= div_nxt;
    chan_r  <= chan_nxt;
    mean_r  <= mean_nxt;
    prod_r  <= prod_nxt;
    omean_r <= omean_nxt;
    omv_r   <= omv_nxt;
    ochan_r <= ochan_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_mean_code  = omean_r;
  assign out_millivolts = omv_r;
  assign out_channel    = ochan_r;

endmodule

`default_nettype wire

>>> rtl/core/adc_sample_averager_to_millivolts.sv
// ----------------------------------------------------------------------------
// adc_sample_averager_to_millivolts
// Boxcar average of converter codes with millivolt conversion.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw converter word per request; code in bits 11:0,
//           channel in bits 20:16.
//   out_* : one result per run of average_count samples: mean code,
//           millivolts = floor(ref_millivolts * mean / 4096) and the channel
//           of the last sample.
//   cfg_* : APB write/read of average_count (0x0) and ref_millivolts (0x4).
// Path: the run that a request ends passes the queue pop, the restoring
//   divider, one multiply and the load of the output register.
// Throughput: one sample per cycle while in_stall is low. The serial divider
//   in the back end takes one run at a time. A two-entry queue of finished
//   runs sits between accumulator and divider.
// Reset: sum and count clear, registers return to 100 and 3302 mV.
// Receiver stall: the result holds in the output register; the back end
//   waits with its next result, the queue fills and then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_sample_averager_to_millivolts
  import asam_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // sample requests
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [WORD_BITS-1:0]      in_result_word,
  // results
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [CODE_BITS-1:0]           out_mean_code,
  output logic [MV_BITS-1:0]             out_millivolts,
  output logic [CHAN_BITS-1:0]           out_channel,
  // configuration
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [APB_ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [APB_DATA_BITS-1:0]  cfg_pwdata,
  output logic [APB_DATA_BITS-1:0]       cfg_prdata,
  output logic                           cfg_pready
);

  logic [CFG_BITS-1:0]   avg_count_r;
  logic [CFG_BITS-1:0]   ref_mv_r;
  logic [COUNT_BITS-1:0] target;
  logic                  cfg_wr;

  asam_fifo_status_t fifo_st;
  asam_job_t         push_job;
  asam_job_t         pop_job;
  logic              push;
  logic              pop;

  // Register file: write on the access phase, read back combinationally
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_count_r <= AVG_COUNT_RESET;
      ref_mv_r    <= REF_MV_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_IDX_AVG_COUNT: avg_count_r <= cfg_pwdata[CFG_BITS-1:0];
        CFG_IDX_REF_MV:    ref_mv_r    <= cfg_pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_IDX_AVG_COUNT: cfg_prdata = APB_DATA_BITS'(avg_count_r);
      CFG_IDX_REF_MV:    cfg_prdata = APB_DATA_BITS'(ref_mv_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // A zero count means one sample per result
  assign target = (avg_count_r == '0) ? COUNT_BITS'(1) : COUNT_BITS'(avg_count_r);

  asam_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_result_word (in_result_word),
    .target         (target),
    .fifo_st        (fifo_st),
    .push           (push),
    .push_job       (push_job)
  );

  asam_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (fifo_st)
  );

  asam_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_st        (fifo_st),
    .pop_job        (pop_job),
    .pop            (pop),
    .ref_mv         (ref_mv_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_code  (out_mean_code),
    .out_millivolts (out_millivolts),
    .out_channel    (out_channel)
  );

endmodule

`default_nettype wire
